### design/line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

`define LR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("line_rasterizer check failed");

`define LR_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("line_rasterizer forbidden condition");

`else

`define LR_ASSERT(label, clk, rst, prop)

`define LR_NEVER(label, clk, rst, expr)

`endif

`endif

### design/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, grid constants, setup and walker types, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

   localparam int COORD_W   = 6;
   localparam int GRID_SIZE = 64;
   localparam int HALF_GRID = GRID_SIZE / 2;
   localparam int DEC_W     = COORD_W + 3;
   localparam int COLOR_W   = 24;
   localparam int REQ_W     = 4 * COORD_W + COLOR_W;
   localparam int RSP_BITS  = 2 * COORD_W + COLOR_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      LR_IDLE,
      LR_SETUP,
      LR_DRAW
   } lr_state_type;

   typedef struct packed {
      logic                    mirror_x;
      logic                    mirror_y;
      logic                    swap;
      logic [COORD_W-1:0]      major_len;
      logic signed [DEC_W-1:0] decision;
      logic signed [DEC_W-1:0] inc_diag;
      logic signed [DEC_W-1:0] inc_straight;
   } lr_setup_type;

   typedef struct packed {
      logic load;
      logic advance;
   } lr_walk_ctrl_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               last;
   } lr_walk_status_type;

endpackage

`default_nettype wire

### design/lr_setup.sv
// ----------------------------------------------------------------------------
// Line rasterizer octant setup
// Maps a line onto the first octant: mirror flags, axis swap, major length,
// initial decision value and the two decision increments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lr_setup (
   input  logic [lr_pkg::COORD_W-1:0] start_x,
   input  logic [lr_pkg::COORD_W-1:0] start_y,
   input  logic [lr_pkg::COORD_W-1:0] end_x,
   input  logic [lr_pkg::COORD_W-1:0] end_y,
   output lr_pkg::lr_setup_type       setup
);
   import lr_pkg::*;

   logic [COORD_W:0]   dx;
   logic [COORD_W:0]   dy;
   logic [COORD_W:0]   neg_dx;
   logic [COORD_W:0]   neg_dy;
   logic               mx;
   logic               my;
   logic               sw;
   logic [COORD_W-1:0] adx;
   logic [COORD_W-1:0] ady;
   logic [COORD_W-1:0] major;
   logic [COORD_W-1:0] minor;
   logic [DEC_W-1:0]   two_minor;

   always_comb begin
      dx        = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
      dy        = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
      neg_dx    = -dx;
      neg_dy    = -dy;
      mx        = dx[COORD_W] || (dx == '0);
      my        = dy[COORD_W] || (dy == '0);
      adx       = mx ? neg_dx[COORD_W-1:0] : dx[COORD_W-1:0];
      ady       = my ? neg_dy[COORD_W-1:0] : dy[COORD_W-1:0];
      sw        = ady > adx;
      major     = sw ? ady : adx;
      minor     = sw ? adx : ady;
      two_minor = DEC_W'({minor, 1'b0});

      setup.mirror_x     = mx;
      setup.mirror_y     = my;
      setup.swap         = sw;
      setup.major_len    = major;
      setup.decision     = two_minor - DEC_W'(major);
      setup.inc_straight = two_minor;
      setup.inc_diag     = two_minor - DEC_W'({major, 1'b0});
   end

endmodule

`default_nettype wire

### design/lr_walker.sv
// ----------------------------------------------------------------------------
// Line rasterizer walker
// Holds the current grid point, decision value and pixel count; one shared
// decision adder advances the point by one pixel per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lr_walker (
   input  logic                       clock,
   input  logic                       reset,
   input  lr_pkg::lr_walk_ctrl_type   ctrl,
   input  lr_pkg::lr_setup_type       setup,
   input  logic [lr_pkg::COORD_W-1:0] start_x,
   input  logic [lr_pkg::COORD_W-1:0] start_y,
   output lr_pkg::lr_walk_status_type status
);
   import lr_pkg::*;

   logic [COORD_W-1:0]      x_ff, x_in;
   logic [COORD_W-1:0]      y_ff, y_in;
   logic [DEC_W-1:0]        d_ff, d_in;
   logic [COORD_W-1:0]      count_ff, count_in;
   logic [COORD_W-1:0]      len_ff, len_in;
   logic                    mx_ff, mx_in;
   logic                    my_ff, my_in;
   logic                    sw_ff, sw_in;
   logic [DEC_W-1:0]        diag_ff, diag_in;
   logic [DEC_W-1:0]        straight_ff, straight_in;
   logic                    step_minor;
   logic                    step_x;
   logic                    step_y;
   logic [COORD_W-1:0]      delta_x;
   logic [COORD_W-1:0]      delta_y;

   always_comb begin
      step_minor = !d_ff[DEC_W-1];
      step_x     = sw_ff ? step_minor : 1'b1;
      step_y     = sw_ff ? 1'b1 : step_minor;
      delta_x    = step_x ? (mx_ff ? '1 : COORD_W'(1)) : '0;
      delta_y    = step_y ? (my_ff ? '1 : COORD_W'(1)) : '0;

      x_in        = x_ff;
      y_in        = y_ff;
      d_in        = d_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      sw_in       = sw_ff;
      diag_in     = diag_ff;
      straight_in = straight_ff;

      if (ctrl.load) begin
         x_in        = start_x;
         y_in        = start_y;
         d_in        = setup.decision;
         count_in    = '0;
         len_in      = setup.major_len;
         mx_in       = setup.mirror_x;
         my_in       = setup.mirror_y;
         sw_in       = setup.swap;
         diag_in     = setup.inc_diag;
         straight_in = setup.inc_straight;
      end else if (ctrl.advance) begin
         x_in     = x_ff + delta_x;
         y_in     = y_ff + delta_y;
         d_in     = d_ff + (step_minor ? diag_ff : straight_ff);
         count_in = count_ff + COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff   <= '0;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      d_ff        <= d_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      sw_ff       <= sw_in;
      diag_ff     <= diag_in;
      straight_ff <= straight_in;
   end

   always_comb begin
      status.pixel_x = x_ff + COORD_W'(HALF_GRID);
      status.pixel_y = y_ff + COORD_W'(HALF_GRID);
      status.last    = (count_ff == len_ff);
   end

endmodule

`default_nettype wire

### design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line drawing: one line command in, one pixel item per point out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one line command per item (start and end point on the
//   centered grid, color). req_tready is high only while no line is in work.
//   rsp channel: one item per pixel, start to end inclusive, in framebuffer
//   coordinates; rsp_tlast marks the final pixel of the line.
//   A line with major extent m gives m+1 pixels. After the command is accepted,
//   the octant setup state (LR_SETUP) loads the walker, then LR_DRAW moves one
//   pixel per cycle into the output register while that register is free; the
//   next command is accepted when the block is back in LR_IDLE.
//   The pixel rate is set by the walker's single decision adder, which
//   advances one point per cycle while the output register is free.
//   The output register holds a pixel while rsp_tready is low; the walker
//   holds its point until the register frees. The next command is accepted
//   in the cycle after the last pixel enters the output register.
//   Reset is synchronous: the block goes idle and the output register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_rasterizer_assert.svh"

module line_rasterizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], color[47:24]
   input  logic [lr_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero[39:36]
   output logic [lr_pkg::RSP_W-1:0] rsp_tdata,
   output logic                     rsp_tlast
);
   import lr_pkg::*;

   lr_state_type       state_ff, state_in;
   logic [REQ_W-1:0]   cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;
   logic               out_load;
   lr_walk_ctrl_type   walk_ctrl;
   lr_walk_status_type walk_status;
   lr_setup_type       setup;
   logic [COORD_W-1:0] cmd_start_x;
   logic [COORD_W-1:0] cmd_start_y;
   logic [COORD_W-1:0] cmd_end_x;
   logic [COORD_W-1:0] cmd_end_y;
   logic [COLOR_W-1:0] cmd_color;

   assign cmd_start_x = cmd_ff[COORD_W-1:0];
   assign cmd_start_y = cmd_ff[2*COORD_W-1:COORD_W];
   assign cmd_end_x   = cmd_ff[3*COORD_W-1:2*COORD_W];
   assign cmd_end_y   = cmd_ff[4*COORD_W-1:3*COORD_W];
   assign cmd_color   = cmd_ff[REQ_W-1:4*COORD_W];

   lr_setup u_setup (
      .start_x (cmd_start_x),
      .start_y (cmd_start_y),
      .end_x   (cmd_end_x),
      .end_y   (cmd_end_y),
      .setup   (setup)
   );

   lr_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (walk_ctrl),
      .setup   (setup),
      .start_x (cmd_start_x),
      .start_y (cmd_start_y),
      .status  (walk_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      walk_ctrl  = '0;
      out_load   = 1'b0;
      out_free   = !rsp_valid_ff || rsp_tready;
      case (state_ff)
         LR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = LR_SETUP;
            end
         end
         LR_SETUP: begin
            walk_ctrl.load = 1'b1;
            state_in       = LR_DRAW;
         end
         LR_DRAW: begin
            if (out_free) begin
               out_load = 1'b1;
               if (walk_status.last) begin
                  state_in = LR_IDLE;
               end else begin
                  walk_ctrl.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = LR_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in       = (req_tvalid && req_tready) ? req_tdata : cmd_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_data_in = RSP_W'({cmd_color, walk_status.pixel_y, walk_status.pixel_x});
         rsp_last_in = walk_status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LR_ASSERT(a_accept_to_setup, clock, reset, (req_tvalid && req_tready) |=> (state_ff == LR_SETUP))
   `LR_NEVER(a_no_step_past_end, clock, reset, walk_ctrl.advance && walk_status.last)
   `LR_ASSERT(a_last_leaves_draw, clock, reset, (out_load && walk_status.last) |=> (state_ff == LR_IDLE))
   `LR_ASSERT(a_load_fills_output, clock, reset, out_load |=> (rsp_valid_ff && (rsp_last_ff == $past(walk_status.last))))

endmodule

`default_nettype wire
